/* rtl/core/arec_pkg.sv */
// Shared types and constants for the auto-ranged elevation colormap.
`default_nettype none

package arec_pkg;

  // Commands carried on the input tuser field
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_COLOR = 2'd2
  } arec_cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SETUP,
    ST_GRAD,
    ST_FIX,
    ST_OUT
  } arec_state_e;

  // Normalized value is unsigned Q1.16
  localparam int unsigned NORM_W = 17;
  localparam logic [NORM_W-1:0] NORM_ONE = 17'd65536;
  localparam logic [NORM_W-1:0] BREAK_LO = 17'd19661;   // 0.3
  localparam logic [NORM_W-1:0] BREAK_HI = 17'd39322;   // 0.6

  // Gradient segment spans
  localparam logic [NORM_W-1:0] SPAN_LO  = BREAK_LO;
  localparam logic [NORM_W-1:0] SPAN_MID = BREAK_HI - BREAK_LO;
  localparam logic [NORM_W-1:0] SPAN_HI  = NORM_ONE - BREAK_HI;

  // Channel dividends stay at or below 255 * SPAN_HI, well under 2^24
  localparam int unsigned LANE_W = 24;
  localparam int unsigned CHAN_W = 8;

  // Reciprocals floor(2^24 / span); with dividends under 2^24 the scaled
  // product is at most one below the true channel quotient
  localparam int unsigned RECIP_SH = 24;
  localparam int unsigned RECIP_W  = 10;
  localparam logic [RECIP_W-1:0] RECIP_LO  = RECIP_W'((32'd1 << RECIP_SH) / 32'(SPAN_LO));
  localparam logic [RECIP_W-1:0] RECIP_MID = RECIP_W'((32'd1 << RECIP_SH) / 32'(SPAN_MID));
  localparam logic [RECIP_W-1:0] RECIP_HI  = RECIP_W'((32'd1 << RECIP_SH) / 32'(SPAN_HI));

  // Step count of the serial divider
  localparam int unsigned STEP_CW = 4;
  localparam logic [STEP_CW-1:0] NORM_LAST = 4'd15;   // 16 quotient bits

  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;

endpackage

`default_nettype wire

/* rtl/core/auto_range_elevation_colormap_unit.sv */
// Top level of the auto-ranged elevation colormap: range tracker and serial divider.
//
// Usage
//   Input stream (s_axis): tuser carries the command, tdata the signed
//   elevation sample. Clear items empty the tracked range, accumulate items
//   widen it to include the sample, colorize items produce one RGB pixel.
//   Output stream (m_axis): one item per colorize item, {blue, green, red}.
//   Alpha is implied 0xFF and not sent.
// Sequencing
//   Clear and accumulate items are handled while idle; ready stays high.
//   A colorize item runs restoring division in the serial compare-subtract
//   unit for the normalized fraction (skipped when the sample lies at or
//   outside the range ends), then segment setup, reciprocal multiply and
//   quotient fix-up, then is written to the output register. Ready stays
//   low from acceptance until that write, so a colorize item must finish
//   before the next item is taken.
// Reset
//   Asynchronous, active low. The range is emptied (low mark at the most
//   positive value, high mark at the most negative) and the block idles.
// Stall
//   A result waits in the output register while m_axis_tready is low; the
//   block keeps taking items until the next pixel needs that register.
`default_nettype none

module auto_range_elevation_colormap_unit
  import arec_pkg::*;
#(
  parameter int unsigned ELEV_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // tdata: elevation [ELEV_WIDTH-1:0], zero padding above
  input  wire logic [((ELEV_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // tuser: cmd [1:0]
  input  wire logic [1:0]                          s_axis_tuser,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: red [7:0], green [15:8], blue [23:16]
  output      logic [3*CHAN_W-1:0]                 m_axis_tdata
);

  localparam int unsigned W  = ELEV_WIDTH;
  // Range register must hold both 2^W - 1 and the unit range 2^FRAC_BITS
  localparam int unsigned RW = (ELEV_WIDTH > FRAC_BITS) ? ELEV_WIDTH : FRAC_BITS + 1;
  // Register width covers the shifted remainder and the channel lanes
  localparam int unsigned UW = ((RW + 1) > LANE_W) ? (RW + 1) : LANE_W;

  localparam logic signed [W-1:0] ELEV_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] ELEV_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [RW-1:0]       UNIT_RANGE = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;

  arec_state_e state_q, state_d;

  logic signed [W-1:0]   low_q, low_d;
  logic signed [W-1:0]   high_q, high_d;
  logic [STEP_CW-1:0]    cnt_q, cnt_d;
  logic [UW-1:0]         rem_q, rem_d;      // remainder, then lane A dividend
  logic [UW-1:0]         div_q, div_d;      // range, then segment span
  logic [LANE_W-1:0]     remb_q, remb_d;    // lane B dividend
  logic [RECIP_W-1:0]    recip_q, recip_d;  // span reciprocal
  logic [NORM_W-1:0]     n_q, n_d;          // normalized fraction
  logic [CHAN_W-1:0]     qa_q, qa_d;
  logic [CHAN_W-1:0]     qb_q, qb_d;
  logic                  lowseg_q, lowseg_d;
  logic                  out_valid_q, out_valid_d;
  logic [3*CHAN_W-1:0]   pix_q, pix_d;

  logic                  in_fire;
  arec_cmd_e             cmd;
  logic                  out_free;
  logic                  out_load;

  // Accept-time range arithmetic
  logic signed [W:0]     e_ext;
  logic signed [W:0]     range_s;
  logic signed [W:0]     diff_s;
  logic [RW-1:0]         range_eff;
  logic                  diff_pos;
  logic                  diff_sat;

  // Compare-subtract unit of the serial divider
  logic [UW-1:0]         unit_x;
  logic [UW:0]           unit_sub;
  logic                  unit_ge;

  // Segment setup
  logic [NORM_W-1:0]     seg_base;
  logic [NORM_W-1:0]     seg_span;
  logic [RECIP_W-1:0]    seg_recip;
  logic                  seg_top;
  logic [LANE_W-1:0]     base_x128;
  logic [LANE_W-1:0]     base_x255;

  // Channel quotients by reciprocal
  logic [LANE_W+RECIP_W-1:0] prod_a;
  logic [LANE_W+RECIP_W-1:0] prod_b;
  logic [CHAN_W:0]           qa_inc;
  logic [CHAN_W:0]           qb_inc;
  logic [CHAN_W+NORM_W-1:0]  next_a;
  logic [CHAN_W+NORM_W-1:0]  next_b;
  logic                      fix_a;
  logic                      fix_b;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cmd      = arec_cmd_e'(s_axis_tuser);
  assign out_free = !out_valid_q || m_axis_tready;

  // e - low and high - low, both one bit wider than the samples
  assign e_ext   = {s_axis_tdata[W-1], s_axis_tdata[W-1:0]};
  assign range_s = {high_q[W-1], high_q} - {low_q[W-1], low_q};
  assign diff_s  = e_ext - {low_q[W-1], low_q};

  // Empty or single-value range counts as 1.0
  assign range_eff = (range_s[W] || (range_s == '0)) ? UNIT_RANGE
                                                     : RW'(range_s[W-1:0]);
  assign diff_pos  = !diff_s[W] && (diff_s != '0);
  // diff >= range means the quotient is at least 1.0
  assign diff_sat  = ((RW+1)'(diff_s[W-1:0]) >= {1'b0, range_eff});

  // Normalizing shifts the remainder left each step
  assign unit_x   = {rem_q[UW-2:0], 1'b0};
  assign unit_sub = {1'b0, unit_x} - {1'b0, div_q};
  assign unit_ge  = !unit_sub[UW];

  // Estimate is floor(x * recip / 2^24), then bumped by one if still short
  assign prod_a = rem_q[LANE_W-1:0] * recip_q;
  assign prod_b = remb_q * recip_q;
  assign qa_inc = {1'b0, qa_q} + 1'b1;
  assign qb_inc = {1'b0, qb_q} + 1'b1;
  assign next_a = qa_inc * div_q[NORM_W-1:0];
  assign next_b = qb_inc * div_q[NORM_W-1:0];
  assign fix_a  = ((CHAN_W+NORM_W)'(rem_q[LANE_W-1:0]) >= next_a);
  assign fix_b  = ((CHAN_W+NORM_W)'(remb_q) >= next_b);

  // Gradient segment of the normalized value
  always_comb begin
    seg_top = 1'b0;
    if (n_q < BREAK_LO) begin
      seg_base  = n_q;
      seg_span  = SPAN_LO;
      seg_recip = RECIP_LO;
    end else if (n_q < BREAK_HI) begin
      seg_base  = BREAK_HI - n_q;          // span minus offset into segment
      seg_span  = SPAN_MID;
      seg_recip = RECIP_MID;
    end else begin
      seg_base  = n_q - BREAK_HI;
      seg_span  = SPAN_HI;
      seg_recip = RECIP_HI;
      seg_top   = 1'b1;
    end
  end

  assign base_x128 = LANE_W'({seg_base, 7'b0});
  assign base_x255 = LANE_W'({seg_base, 8'b0}) - LANE_W'(seg_base);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (cmd == CMD_COLOR)) begin
          state_d = (diff_pos && !diff_sat) ? ST_NORM : ST_SETUP;
        end
      end
      ST_NORM: begin
        if (cnt_q == '0) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_GRAD;
      ST_GRAD:  state_d = ST_FIX;
      ST_FIX:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and range updates
  always_comb begin
    low_d    = low_q;
    high_d   = high_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    div_d    = div_q;
    remb_d   = remb_q;
    recip_d  = recip_q;
    n_d      = n_q;
    qa_d     = qa_q;
    qb_d     = qb_q;
    lowseg_d = lowseg_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_CLEAR: begin
              low_d  = ELEV_MAX;
              high_d = ELEV_MIN;
            end
            CMD_ACCUM: begin
              if ($signed(s_axis_tdata[W-1:0]) < low_q) begin
                low_d = s_axis_tdata[W-1:0];
              end
              if ($signed(s_axis_tdata[W-1:0]) > high_q) begin
                high_d = s_axis_tdata[W-1:0];
              end
            end
            CMD_COLOR: begin
              rem_d = UW'(diff_s[W-1:0]);
              div_d = UW'(range_eff);
              cnt_d = NORM_LAST;
              if (!diff_pos) begin
                n_d = '0;
              end else if (diff_sat) begin
                n_d = NORM_ONE;
              end else begin
                n_d = '0;
              end
            end
            default: ;   // unused code: no effect
          endcase
        end
      end
      ST_NORM: begin
        rem_d = unit_ge ? unit_sub[UW-1:0] : unit_x;
        n_d   = {n_q[NORM_W-2:0], unit_ge};
        cnt_d = cnt_q - 1'b1;
      end
      ST_SETUP: begin
        rem_d    = UW'(seg_top ? base_x255 : base_x128);
        remb_d   = base_x255;
        div_d    = UW'(seg_span);
        recip_d  = seg_recip;
        lowseg_d = (n_q < BREAK_LO);
      end
      ST_GRAD: begin
        qa_d = prod_a[RECIP_SH +: CHAN_W];
        qb_d = prod_b[RECIP_SH +: CHAN_W];
      end
      ST_FIX: begin
        qa_d = qa_q + CHAN_W'(fix_a);
        qb_d = qb_q + CHAN_W'(fix_b);
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // Handshake and result outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    out_load      = (state_q == ST_OUT) && out_free;
    out_valid_d   = out_load || (out_valid_q && !m_axis_tready);
    // Low segment: red 128n/S, green 255n/S, blue full.
    // Other segments: green full, blue from lane B (equals red at the top).
    pix_d = out_load ? {lowseg_q ? CHAN_FULL : qb_q,
                        lowseg_q ? qb_q : CHAN_FULL,
                        qa_q}
                     : pix_q;
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_q       <= ELEV_MAX;
      high_q      <= ELEV_MIN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      high_q      <= high_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    div_q    <= div_d;
    remb_q   <= remb_d;
    recip_q  <= recip_d;
    n_q      <= n_d;
    qa_q     <= qa_d;
    qb_q     <= qb_d;
    lowseg_q <= lowseg_d;
    pix_q    <= pix_d;
  end

endmodule

`default_nettype wire
